[sv/fetch_interface_checker_unit_assert.svh]
// Assertion macros for the fetch interface checker
// Used by the top level only; expects clk and rst in scope
`ifndef FETCH_INTERFACE_CHECKER_UNIT_ASSERT_SVH
`define FETCH_INTERFACE_CHECKER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define FCU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fetch checker assertion failed");
`define FCU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fetch checker assertion failed");
`else
`define FCU_ASSERT_SAME(label, ante, cons)
`define FCU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/fcu_pkg.sv]
// Shared types, constants and the shadow check function of the fetch checker
// No dependencies
package fcu_pkg;

  localparam int WINDOW_WORD_BITS = 14;
  localparam int ROW_BITS         = WINDOW_WORD_BITS - 1;
  localparam int ROWS             = 2 ** ROW_BITS;

  localparam logic [31:0] MASK_WORD      = 32'hffff_ffff;
  localparam logic [31:0] MASK_HALF_HIGH = 32'hffff_0000;
  localparam logic [31:0] MASK_HALF_LOW  = 32'h0000_ffff;

  // request kinds
  localparam logic [2:0] REQ_NONE   = 3'd0;
  localparam logic [2:0] REQ_NONSEQ = 3'd1;
  localparam logic [2:0] REQ_SEQ32  = 3'd2;
  localparam logic [2:0] REQ_REPEAT = 3'd3;
  localparam logic [2:0] REQ_SEQ16  = 3'd6;

  // low address bits
  localparam logic [1:0] ALIGN_WORD = 2'd0;
  localparam logic [1:0] ALIGN_ODD0 = 2'd1;
  localparam logic [1:0] ALIGN_HALF = 2'd2;
  localparam logic [1:0] ALIGN_ODD1 = 2'd3;

  typedef logic [ROW_BITS-1:0] row_t;

  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] data;
  } shadow_entry_t;

  typedef struct packed {
    logic          bad;
    shadow_entry_t entry;
  } check_res_t;

  // decoded item handed from the request stage to the data check stage
  typedef struct packed {
    logic        step_err;
    logic        idle_err;
    logic        unexp;
    logic        odd;
    logic        outside;
    logic        check_en;
    logic        halfword;
    logic        first_odd;
    row_t        even_row;
    row_t        odd_row;
    logic [31:0] data;
    logic [31:0] cycle;
  } req_info_t;

  // compare known bits, then merge new bits into the entry
  function automatic check_res_t shadow_check_set(shadow_entry_t ent, logic [31:0] data,
                                                  logic [31:0] mask);
    check_res_t  r;
    logic [31:0] both;
    both         = ent.mask & mask;
    r.bad        = (ent.data & both) != (data & both);
    r.entry.mask = ent.mask | mask;
    r.entry.data = (ent.data & ~mask) | (data & mask);
    return r;
  endfunction

endpackage

[sv/fcu_fetch_if.sv]
// Input channel of the fetch checker: one fetch observation per item
// No dependencies
interface fcu_fetch_if;
  logic        valid;
  logic        ready;
  logic [2:0]  fetch_kind;
  logic [31:0] req_address;
  logic        resp_valid;
  logic [31:0] resp_data;

  modport source (output valid, fetch_kind, req_address, resp_valid, resp_data, input ready);
  modport sink   (input valid, fetch_kind, req_address, resp_valid, resp_data, output ready);
endinterface

[sv/fcu_result_if.sv]
// Output channel of the fetch checker: one check result per item
// No dependencies
interface fcu_result_if;
  logic        valid;
  logic        ready;
  logic        check_failed;
  logic        address_step_error;
  logic        after_idle_error;
  logic        unexpected_response;
  logic        data_mismatch;
  logic        odd_address;
  logic        outside_window;
  logic [31:0] stored_data;
  logic [31:0] error_cycle;

  modport source (output valid, check_failed, address_step_error, after_idle_error,
                  unexpected_response, data_mismatch, odd_address, outside_window,
                  stored_data, error_cycle, input ready);
  modport sink   (input valid, check_failed, address_step_error, after_idle_error,
                  unexpected_response, data_mismatch, odd_address, outside_window,
                  stored_data, error_cycle, output ready);
endinterface

[sv/fcu_shadow_bank.sv]
// One bank of the shadow store: one write port, one registered read port
// Depends on fcu_pkg
module fcu_shadow_bank
  import fcu_pkg::*;
(
  input  logic          clk,
  input  logic          wr_en,
  input  row_t          wr_row,
  input  shadow_entry_t wr_data,
  input  logic          rd_en,
  input  row_t          rd_row,
  output shadow_entry_t rd_data
);

  shadow_entry_t mem [ROWS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
  end

  // read port, old data on a same-row write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

[sv/fcu_step_check.sv]
// Request stage: address step checks, response decode and shadow row selection
// Depends on fcu_pkg
module fcu_step_check
  import fcu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [2:0]  fetch_kind,
  input  logic [31:0] req_address,
  input  logic        resp_valid,
  input  logic [31:0] resp_data,
  output req_info_t   info
);

  logic [2:0]  last_type;
  logic [31:0] last_address;
  logic [31:0] cycle_count;

  logic        is_step;
  logic [31:0] inc;
  logic [29:0] word;
  logic [30:0] word_p1;
  logic        word_out;
  logic        word_p1_out;
  logic        checked;
  logic        aligned;
  logic        halfword;
  logic        odd;

  // previous request and item counter
  always_ff @(posedge clk) begin
    if (rst) begin
      last_type    <= REQ_NONE;
      last_address <= '0;
      cycle_count  <= '0;
    end else if (accept) begin
      last_type    <= fetch_kind;
      last_address <= req_address;
      cycle_count  <= cycle_count + 32'd1;
    end
  end

  // expected step per request kind
  always_comb begin
    is_step = 1'b0;
    inc     = '0;
    unique case (fetch_kind)
      REQ_REPEAT: begin
        is_step = 1'b1;
        inc     = 32'd0;
      end
      REQ_SEQ16: begin
        is_step = 1'b1;
        inc     = 32'd2;
      end
      REQ_SEQ32: begin
        is_step = 1'b1;
        inc     = 32'd4;
      end
      default: begin
        is_step = 1'b0;
      end
    endcase
  end

  // alignment decode
  always_comb begin
    aligned  = 1'b0;
    halfword = 1'b0;
    odd      = 1'b0;
    unique case (req_address[1:0]) inside
      ALIGN_WORD:             aligned  = 1'b1;
      ALIGN_HALF:             halfword = 1'b1;
      ALIGN_ODD0, ALIGN_ODD1: odd      = 1'b1;
      default:                odd      = 1'b1;
    endcase
  end

  assign word        = req_address[31:2];
  assign word_p1     = {1'b0, word} + 31'd1;
  assign word_out    = ({2'b00, word} >> WINDOW_WORD_BITS) != 32'd0;
  assign word_p1_out = ({1'b0, word_p1} >> WINDOW_WORD_BITS) != 32'd0;
  assign checked     = resp_valid && (fetch_kind != REQ_NONE);

  // decoded item
  always_comb begin
    info.step_err  = is_step && ((last_address + inc) != req_address);
    info.idle_err  = is_step && (last_type == REQ_NONE);
    info.unexp     = resp_valid && (fetch_kind == REQ_NONE);
    info.odd       = checked && odd;
    info.outside   = checked && ((aligned && word_out) || (halfword && word_p1_out));
    info.check_en  = checked && ((aligned && !word_out) || (halfword && !word_p1_out));
    info.halfword  = halfword;
    info.first_odd = word[0];
    info.odd_row   = word[WINDOW_WORD_BITS-1:1];
    info.even_row  = word[WINDOW_WORD_BITS-1:1] + row_t'(word[0]);
    info.data      = resp_data;
    info.cycle     = cycle_count;
  end

endmodule

[sv/fetch_interface_checker_unit.sv]
// Fetch interface checker: one fetch observation in, one check result out per item.
// Accepted items are held in the check stage register, then results in the output register; throughput
// 1 item per cycle unless the output stalls; the shadow store banks take one read and one write each per cycle.
// Reset: synchronous; clears request history, counters and the output, then a clearing pass writes
// every one of the 2^(WINDOW_WORD_BITS-1) = 8192 shadow rows, with no item accepted meanwhile.
// Depends on fcu_pkg, fcu_fetch_if, fcu_result_if, fcu_step_check, fcu_shadow_bank
`include "fetch_interface_checker_unit_assert.svh"
module fetch_interface_checker_unit
  import fcu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  fcu_fetch_if.sink           fetch,
  fcu_result_if.source        result
);

  logic          clearing;
  row_t          clear_row;
  logic          in_ready;
  logic          accept;
  req_info_t     info;
  logic          s1_valid;
  req_info_t     s1;
  logic          s1_adv;
  shadow_entry_t rd_even;
  shadow_entry_t rd_odd;
  logic          fwd_even_valid;
  row_t          fwd_even_row;
  shadow_entry_t fwd_even_data;
  logic          fwd_odd_valid;
  row_t          fwd_odd_row;
  shadow_entry_t fwd_odd_data;
  shadow_entry_t ent_even;
  shadow_entry_t ent_odd;
  shadow_entry_t ent_first;
  shadow_entry_t ent_second;
  logic [31:0]   data_first;
  logic [31:0]   mask_first;
  check_res_t    chk_first;
  check_res_t    chk_second;
  logic          mism_first;
  logic          mism_second;
  logic          wr_first;
  logic          wr_second;
  logic          any_err;
  logic          upd_even;
  logic          upd_odd;
  shadow_entry_t upd_even_data;
  shadow_entry_t upd_odd_data;
  logic          wr_even_en;
  row_t          wr_even_row;
  shadow_entry_t wr_even_data;
  logic          wr_odd_en;
  row_t          wr_odd_row;
  shadow_entry_t wr_odd_data;
  logic [31:0]   held_error_cycle;
  logic          flags_any;

  // handshake
  assign s1_adv      = s1_valid && (!result.valid || result.ready);
  assign in_ready    = !clearing && (!s1_valid || s1_adv);
  assign fetch.ready = in_ready;
  assign accept      = fetch.valid && in_ready;

  // request stage
  fcu_step_check u_step (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .fetch_kind  (fetch.fetch_kind),
    .req_address (fetch.req_address),
    .resp_valid  (fetch.resp_valid),
    .resp_data   (fetch.resp_data),
    .info        (info)
  );

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_row <= '0;
    end else if (clearing) begin
      clear_row <= clear_row + row_t'(1);
      if (&clear_row) begin
        clearing <= 1'b0;
      end
    end
  end

  // check stage holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= info;
    end
  end

  // even and odd word banks
  fcu_shadow_bank u_bank_even (
    .clk     (clk),
    .wr_en   (wr_even_en),
    .wr_row  (wr_even_row),
    .wr_data (wr_even_data),
    .rd_en   (accept),
    .rd_row  (info.even_row),
    .rd_data (rd_even)
  );

  fcu_shadow_bank u_bank_odd (
    .clk     (clk),
    .wr_en   (wr_odd_en),
    .wr_row  (wr_odd_row),
    .wr_data (wr_odd_data),
    .rd_en   (accept),
    .rd_row  (info.odd_row),
    .rd_data (rd_odd)
  );

  // forward the last write of each bank over a stale read
  assign ent_even = (fwd_even_valid && (fwd_even_row == s1.even_row)) ? fwd_even_data : rd_even;
  assign ent_odd  = (fwd_odd_valid && (fwd_odd_row == s1.odd_row)) ? fwd_odd_data : rd_odd;

  // shadow check of the first and second word
  always_comb begin
    ent_first   = s1.first_odd ? ent_odd : ent_even;
    ent_second  = s1.first_odd ? ent_even : ent_odd;
    data_first  = s1.halfword ? {s1.data[15:0], 16'h0000} : s1.data;
    mask_first  = s1.halfword ? MASK_HALF_HIGH : MASK_WORD;
    chk_first   = shadow_check_set(ent_first, data_first, mask_first);
    chk_second  = shadow_check_set(ent_second, {16'h0000, s1.data[31:16]}, MASK_HALF_LOW);
    mism_first  = s1.check_en && chk_first.bad;
    mism_second = s1.check_en && s1.halfword && !chk_first.bad && chk_second.bad;
    wr_first    = s1.check_en;
    wr_second   = s1.check_en && s1.halfword && !chk_first.bad;
    any_err     = s1.step_err || s1.idle_err || s1.unexp || s1.odd || s1.outside ||
                  mism_first || mism_second;
  end

  // write back, or zero rows while clearing
  always_comb begin
    upd_even      = s1_adv && ((wr_first && !s1.first_odd) || (wr_second && s1.first_odd));
    upd_odd       = s1_adv && ((wr_first && s1.first_odd) || (wr_second && !s1.first_odd));
    upd_even_data = s1.first_odd ? chk_second.entry : chk_first.entry;
    upd_odd_data  = s1.first_odd ? chk_first.entry : chk_second.entry;
    wr_even_en    = clearing || upd_even;
    wr_even_row   = clearing ? clear_row : s1.even_row;
    wr_even_data  = clearing ? shadow_entry_t'('0) : upd_even_data;
    wr_odd_en     = clearing || upd_odd;
    wr_odd_row    = clearing ? clear_row : s1.odd_row;
    wr_odd_data   = clearing ? shadow_entry_t'('0) : upd_odd_data;
  end

  // forwarding registers
  always_ff @(posedge clk) begin
    if (rst || clearing) begin
      fwd_even_valid <= 1'b0;
      fwd_odd_valid  <= 1'b0;
    end else begin
      if (upd_even) begin
        fwd_even_valid <= 1'b1;
      end
      if (upd_odd) begin
        fwd_odd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_even) begin
      fwd_even_row  <= s1.even_row;
      fwd_even_data <= upd_even_data;
    end
    if (upd_odd) begin
      fwd_odd_row  <= s1.odd_row;
      fwd_odd_data <= upd_odd_data;
    end
  end

  // output register and held error cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid     <= 1'b0;
      held_error_cycle <= '0;
    end else begin
      if (s1_adv) begin
        result.valid <= 1'b1;
        if (any_err) begin
          held_error_cycle <= s1.cycle;
        end
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.check_failed        <= any_err;
      result.address_step_error  <= s1.step_err;
      result.after_idle_error    <= s1.idle_err;
      result.unexpected_response <= s1.unexp;
      result.data_mismatch       <= mism_first || mism_second;
      result.odd_address         <= s1.odd;
      result.outside_window      <= s1.outside;
      result.stored_data         <= mism_first ? ent_first.data :
                                    (mism_second ? ent_second.data : 32'd0);
      result.error_cycle         <= any_err ? s1.cycle : held_error_cycle;
    end
  end

  // or of the individual result flags
  assign flags_any = result.address_step_error || result.after_idle_error ||
                     result.unexpected_response || result.data_mismatch ||
                     result.odd_address || result.outside_window;

  // checks
  `FCU_ASSERT_SAME(a_no_write_while_clearing, clearing, !s1_adv && !accept)
  `FCU_ASSERT_NEXT(a_adv_gives_result, s1_adv, result.valid)
  `FCU_ASSERT_SAME(a_error_summary, result.valid, result.check_failed == flags_any)
  `FCU_ASSERT_SAME(a_seen_only_on_mismatch, result.valid && !result.data_mismatch, result.stored_data == 32'd0)

endmodule
